FILE: rtl/core/iarl_pkg.sv
// Package for the indexed array list: operation kinds, result status codes,
// controller states and the control bundle sent to the storage cells.
// Used by every module of the block; depends on nothing.
package iarl_pkg;

    typedef enum logic [2:0] {
        KIND_PUSH   = 3'd0,
        KIND_READ   = 3'd1,
        KIND_WRITE  = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_FIND   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    typedef struct packed {
        logic push;
        logic set;
        logic shift;
        logic find;
    } t_cell_ctrl;

    localparam int KIND_BITS = 3;
    localparam int POS_BITS = 6;
    localparam int IN_VALUE_BITS = 32;
    localparam int OUT_VALUE_BITS = 32;
    localparam int OUT_POS_BITS = 7;
    localparam int OUT_LEN_BITS = 7;
    localparam logic [OUT_POS_BITS-1:0] FOUND_NONE = '1;

endpackage

FILE: rtl/core/iarl_cell.sv
// One storage cell of the list: holds a single slot, loads the element on a push or
// write, takes its upper neighbor's value on a removal and flags a read or find hit.
// Depends on iarl_pkg.
module iarl_cell import iarl_pkg::*; #(
    parameter int INDEX = 0,
    parameter int IDX_BITS = 6,
    parameter int CNT_BITS = 7,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [IDX_BITS-1:0]   i_slot,
    input  logic [CNT_BITS-1:0]   i_count,
    input  logic [VALUE_BITS-1:0] i_elem,
    input  logic [VALUE_BITS-1:0] i_upper,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_hit
);

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);
    localparam logic [CNT_BITS-1:0] MY_CNT = CNT_BITS'(INDEX);

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;

    always_comb begin
        priority if (i_ctrl.push && (MY_CNT == i_count)) begin
            n_value = i_elem;
        end else if (i_ctrl.set && (MY_IDX == i_slot)) begin
            n_value = i_elem;
        end else if (i_ctrl.shift && (MY_IDX >= i_slot)) begin
            n_value = i_upper;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_hit = i_ctrl.find ? ((r_value == i_elem) && (MY_CNT < i_count))
                               : (MY_IDX == i_slot);

endmodule

FILE: rtl/core/iarl_tree.sv
// Registered selection tree over the cell hit flags: one level per cycle,
// the lowest hitting slot wins and carries its index and value to the root.
// Depends on iarl_pkg.
module iarl_tree import iarl_pkg::*; #(
    parameter int LEAVES = 64,
    parameter int IDX_BITS = 6,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [LEAVES-1:0]     i_hit,
    input  logic [VALUE_BITS-1:0] i_value [LEAVES],
    output logic                  o_hit,
    output logic [IDX_BITS-1:0]   o_idx,
    output logic [VALUE_BITS-1:0] o_value
);

    localparam int P2 = 1 << IDX_BITS;
    localparam int NODES = 2 * P2 - 1;

    logic                  r_hit [NODES];
    logic [IDX_BITS-1:0]   r_idx [NODES];
    logic [VALUE_BITS-1:0] r_val [NODES];

    genvar k;
    generate
        for (k = 0; k < P2; k++) begin : g_leaf
            if (k < LEAVES) begin : g_used
                always_ff @(posedge i_clk) begin
                    if (i_load) begin
                        r_hit[P2-1+k] <= i_hit[k];
                        r_idx[P2-1+k] <= IDX_BITS'(k);
                        r_val[P2-1+k] <= i_value[k];
                    end
                end
            end else begin : g_pad
                always_ff @(posedge i_clk) begin
                    if (i_load) begin
                        r_hit[P2-1+k] <= 1'b0;
                        r_idx[P2-1+k] <= IDX_BITS'(k);
                        r_val[P2-1+k] <= '0;
                    end
                end
            end
        end
        for (k = 0; k < P2 - 1; k++) begin : g_node
            always_ff @(posedge i_clk) begin
                r_hit[k] <= r_hit[2*k+1] | r_hit[2*k+2];
                r_idx[k] <= r_hit[2*k+1] ? r_idx[2*k+1] : r_idx[2*k+2];
                r_val[k] <= r_hit[2*k+1] ? r_val[2*k+1] : r_val[2*k+2];
            end
        end
    endgenerate

    assign o_hit = r_hit[0];
    assign o_idx = r_idx[0];
    assign o_value = r_val[0];

endmodule

FILE: rtl/core/indexed_array_list.sv
// Top level of the indexed array list: stream ports, controller, the row of
// storage cells and the registered selection tree for read and find.
// Depends on iarl_pkg, iarl_cell and iarl_tree.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: kind; tdata: position, value
//   m_axis    out        tuser: status; tdata: read_value, found_position, list_length
//
// Push, write, remove, unused kinds and out-of-range accesses register a result
// in the cycle after acceptance; a new transaction is accepted every cycle while
// the result is taken. A valid read or any find loads the registered selection tree
// and waits in the search state for the root; no transaction is accepted meanwhile.
// Reset clears the count, state and output valid; slots hold no value until written.
// A stalled result holds in the output register and blocks further transactions.
module indexed_array_list import iarl_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // position [5:0], value [37:6], zero [39:38]
    input  logic [2:0]  s_axis_tuser,  // kind [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // read_value [31:0], found_position [38:32],
                                       // list_length [45:39], zero [47:46]
    output logic [1:0]  m_axis_tuser   // status [1:0]
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > OUT_LEN_BITS) ? CW : OUT_LEN_BITS;
    localparam int WB = $clog2(IW + 1);

    t_kind                   w_kind;
    logic [POS_BITS-1:0]     w_pos;
    logic [VALUE_BITS-1:0]   w_elem;
    logic                    w_accept;
    logic [XW-1:0]           w_cnt_x;
    logic [XW-1:0]           w_slot_x;
    logic [XW-1:0]           w_len_x;
    logic [XW-1:0]           w_found_x;
    logic [IW-1:0]           w_slot;
    logic                    w_in_range;
    logic                    w_full;
    logic                    w_search;
    t_status                 w_status;
    t_cell_ctrl              w_ctrl;
    logic [CAPACITY-1:0]     w_hit;
    logic [VALUE_BITS-1:0]   w_cell_value [CAPACITY];
    logic                    w_root_hit;
    logic [IW-1:0]           w_root_idx;
    logic [VALUE_BITS-1:0]   w_root_value;

    t_state                  r_state;
    t_state                  n_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [WB-1:0]           r_wait;
    logic [WB-1:0]           n_wait;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic                    r_pend_read;
    logic                    n_pend_read;
    logic [OUT_VALUE_BITS-1:0] r_out_read;
    logic [OUT_VALUE_BITS-1:0] n_out_read;
    logic [OUT_POS_BITS-1:0] r_out_found;
    logic [OUT_POS_BITS-1:0] n_out_found;
    logic [OUT_LEN_BITS-1:0] r_out_len;
    logic [OUT_LEN_BITS-1:0] n_out_len;
    t_status                 r_out_status;
    t_status                 n_out_status;

    assign w_kind = t_kind'(s_axis_tuser);
    assign w_pos = s_axis_tdata[5:0];
    assign w_elem = VALUE_BITS'($signed(s_axis_tdata[37:6]));

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign w_cnt_x = XW'(r_count);
    assign w_in_range = XW'(w_pos) < w_cnt_x;
    assign w_slot_x = w_cnt_x - XW'(1) - XW'(w_pos);
    assign w_slot = w_slot_x[IW-1:0];
    assign w_full = (r_count == CW'(CAPACITY));

    always_comb begin
        w_ctrl = '0;
        w_status = ST_OK;
        w_search = 1'b0;
        n_count = r_count;
        unique case (w_kind)
            KIND_PUSH: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.push = w_accept;
                    n_count = r_count + CW'(1);
                end
            end
            KIND_READ: begin
                if (w_in_range) begin
                    w_search = 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            KIND_WRITE: begin
                if (w_in_range) begin
                    w_ctrl.set = w_accept;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            KIND_REMOVE: begin
                if (w_in_range) begin
                    w_ctrl.shift = w_accept;
                    n_count = r_count - CW'(1);
                end else begin
                    w_status = ST_RANGE;
                end
            end
            KIND_FIND: begin
                w_search = 1'b1;
                w_ctrl.find = 1'b1;
            end
            default: begin
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VALUE_BITS-1:0] w_upper;
            if (g == CAPACITY - 1) begin : g_top
                assign w_upper = w_cell_value[g];
            end else begin : g_mid
                assign w_upper = w_cell_value[g+1];
            end
            iarl_cell #(
                .INDEX      (g),
                .IDX_BITS   (IW),
                .CNT_BITS   (CW),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_slot  (w_slot),
                .i_count (r_count),
                .i_elem  (w_elem),
                .i_upper (w_upper),
                .o_value (w_cell_value[g]),
                .o_hit   (w_hit[g])
            );
        end
    endgenerate

    iarl_tree #(
        .LEAVES     (CAPACITY),
        .IDX_BITS   (IW),
        .VALUE_BITS (VALUE_BITS)
    ) u_tree (
        .i_clk   (i_clk),
        .i_load  (w_accept && w_search),
        .i_hit   (w_hit),
        .i_value (w_cell_value),
        .o_hit   (w_root_hit),
        .o_idx   (w_root_idx),
        .o_value (w_root_value)
    );

    assign w_len_x = XW'(n_count);
    assign w_found_x = w_cnt_x - XW'(1) - XW'(w_root_idx);

    always_comb begin
        n_state = r_state;
        n_wait = r_wait;
        n_pend_read = r_pend_read;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_read = r_out_read;
        n_out_found = r_out_found;
        n_out_len = r_out_len;
        n_out_status = r_out_status;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_search) begin
                    n_state = S_SEARCH;
                    n_wait = WB'(IW);
                    n_pend_read = (w_kind == KIND_READ);
                end else if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_out_read = '0;
                    n_out_found = FOUND_NONE;
                    n_out_len = w_len_x[OUT_LEN_BITS-1:0];
                    n_out_status = w_status;
                end
            end
            S_SEARCH: begin
                if (r_wait == '0) begin
                    n_state = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_len = w_cnt_x[OUT_LEN_BITS-1:0];
                    n_out_status = ST_OK;
                    if (r_pend_read) begin
                        n_out_read = OUT_VALUE_BITS'(w_root_value);
                        n_out_found = FOUND_NONE;
                    end else begin
                        n_out_read = '0;
                        n_out_found = w_root_hit ? w_found_x[OUT_POS_BITS-1:0]
                                                 : FOUND_NONE;
                    end
                end else begin
                    n_wait = r_wait - WB'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_wait <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= (w_accept ? n_count : r_count);
            r_wait <= n_wait;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_read <= n_pend_read;
        r_out_read <= n_out_read;
        r_out_found <= n_out_found;
        r_out_len <= n_out_len;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {2'b00, r_out_len, r_out_found, r_out_read};
    assign m_axis_tuser = r_out_status;

    a_no_accept_in_search: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> !s_axis_tready
    ) else $error("transaction accepted during a search");

    a_count_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)
    ) else $error("element count above capacity");

    a_full_push_dropped: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_kind == KIND_PUSH) && w_full) |=> (r_count == CW'(CAPACITY))
    ) else $error("push on a full list changed the count");

    a_search_delivers: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEARCH) && (r_wait == '0)) |=> m_axis_tvalid
    ) else $error("search finished without a result");

    a_search_keeps_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |=> $stable(r_count)
    ) else $error("element count changed during a search");

endmodule

FILE: verif/indexed_array_list_checker.sv
// Checker for the indexed array list: watches both stream channels, predicts every
// result from its own copy of the list and compares each returned transaction.
// Depends on iarl_pkg for the kind and status codes and the result field widths.
module indexed_array_list_checker import iarl_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // position [5:0], value [37:6], zero [39:38]
    input  logic [2:0]  i_s_axis_tuser,  // kind [2:0]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [47:0] i_m_axis_tdata,  // read_value [31:0], found_position [38:32],
                                         // list_length [45:39], zero [47:46]
    input  logic [1:0]  i_m_axis_tuser,  // status [1:0]
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_full_drops,
    output int          o_range_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0]             read_value;
        logic [OUT_POS_BITS-1:0] found_position;
        logic [OUT_LEN_BITS-1:0] list_length;
        logic [1:0]              status;
    } t_list_result;

    logic [31:0]  slots [CAPACITY];
    int           count;
    t_list_result expected_q [$];
    int           fails;
    int           checked;
    int           full_drops;
    int           range_hits;

    assign o_fail_count = fails;
    assign o_checked    = checked;
    assign o_full_drops = full_drops;
    assign o_range_hits = range_hits;

    task automatic report_mismatch(input string note);
        $display("%0t ns: %s", $time, note);
        fails++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v);
        if (got_v !== want_v) begin
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      checked, name, got_v, want_v));
        end
    endtask

    // Logical position p lives in slot count-1-p, so the front is the highest slot.
    function automatic t_list_result apply_list_op(input logic [2:0] kind,
                                                   input logic [5:0] pos,
                                                   input logic [31:0] value);
        t_list_result r;
        int           slot;
        r.read_value     = '0;
        r.found_position = FOUND_NONE;
        r.status         = ST_OK;
        case (kind)
            KIND_PUSH: begin
                if (count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    slots[count] = value;
                    count++;
                end
            end
            KIND_READ, KIND_WRITE, KIND_REMOVE: begin
                if (int'(pos) >= count) begin
                    r.status = ST_RANGE;
                end else begin
                    slot = count - 1 - int'(pos);
                    if (kind == KIND_READ) begin
                        r.read_value = slots[slot];
                    end else if (kind == KIND_WRITE) begin
                        slots[slot] = value;
                    end else begin
                        for (int j = slot; j + 1 < count; j++) begin
                            slots[j] = slots[j + 1];
                        end
                        count--;
                    end
                end
            end
            KIND_FIND: begin
                // Scan downward so the lowest matching slot is the one kept.
                for (int j = count - 1; j >= 0; j--) begin
                    if (slots[j] == value) begin
                        r.found_position = OUT_POS_BITS'(count - 1 - j);
                    end
                end
            end
            default: begin
            end
        endcase
        r.list_length = OUT_LEN_BITS'(count);
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            count = 0;
            expected_q.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.read_value     = i_m_axis_tdata[31:0];
                got.found_position = i_m_axis_tdata[38:32];
                got.list_length    = i_m_axis_tdata[45:39];
                got.status         = i_m_axis_tuser;
                if (expected_q.size() == 0) begin
                    report_mismatch("result transaction arrived with none outstanding");
                end else begin
                    want = expected_q.pop_front();
                    check_field("read_value", got.read_value, want.read_value);
                    check_field("found_position", 32'(got.found_position),
                                32'(want.found_position));
                    check_field("list_length", 32'(got.list_length), 32'(want.list_length));
                    check_field("status", 32'(got.status), 32'(want.status));
                    checked++;
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                want = apply_list_op(i_s_axis_tuser, i_s_axis_tdata[5:0],
                                     i_s_axis_tdata[37:6]);
                if (want.status == ST_FULL) begin
                    full_drops++;
                end
                if (want.status == ST_RANGE) begin
                    range_hits++;
                end
                expected_q.push_back(want);
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

FILE: verif/indexed_array_list_tb.sv
// Testbench top for the indexed array list: clock, reset, directed and random
// stimulus with random idling on both channels, watchdog and verdict.
// Depends on iarl_pkg, the block indexed_array_list and indexed_array_list_checker.
module indexed_array_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iarl_pkg::*;

    localparam int          LIST_CAPACITY      = 64;
    localparam int          RESET_CYCLES       = 9;
    localparam int          RANDOM_ITEMS       = 800;
    localparam int          BURST_ITEMS        = 100;
    localparam int          STALL_LIMIT        = 2000;
    localparam int          DRAIN_CYCLES       = 16;
    localparam int          POOL_DEPTH         = 16;
    localparam logic [2:0]  KIND_UNUSED_FIRST  = 3'd5;
    localparam logic [2:0]  KIND_UNUSED_LAST   = 3'd7;
    localparam logic [5:0]  POS_LAST           = 6'd63;
    localparam logic [31:0] VALUE_MIN          = 32'h8000_0000;
    localparam logic [31:0] VALUE_MAX          = 32'h7fff_ffff;
    localparam logic [31:0] VALUE_ALL_ONES     = 32'hffff_ffff;

    typedef enum logic [1:0] {
        MODE_GROW,
        MODE_MIXED,
        MODE_SHRINK
    } t_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // position [5:0], value [37:6], zero [39:38]
    logic [2:0]  s_axis_tuser = '0;    // kind [2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // read_value [31:0], found_position [38:32],
                                       // list_length [45:39], zero [47:46]
    logic [1:0]  m_axis_tuser;         // status [1:0]

    int          fail_count;
    int          pending;
    int          checked;
    int          full_drops;
    int          range_hits;

    bit          no_idle = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          list_len_guess = 0;
    int          kind_count [8];
    logic [31:0] value_pool [$];

    indexed_array_list #(
        .CAPACITY   (LIST_CAPACITY),
        .VALUE_BITS (32)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    indexed_array_list_checker #(
        .CAPACITY (LIST_CAPACITY)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_drops    (full_drops),
        .o_range_hits    (range_hits)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : result_sink
        int stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            stall_left <= stall;
            m_axis_tready <= (stall == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a transaction.", idle_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [2:0] kind, input logic [5:0] pos,
                             input logic [31:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, value, pos};
        s_axis_tuser <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        kind_count[kind]++;
        if (kind == KIND_PUSH && list_len_guess < LIST_CAPACITY) begin
            list_len_guess++;
        end
        if (kind == KIND_REMOVE && int'(pos) < list_len_guess) begin
            list_len_guess--;
        end
        if (kind == KIND_PUSH || kind == KIND_WRITE) begin
            value_pool.push_back(value);
            if (value_pool.size() > POOL_DEPTH) begin
                void'(value_pool.pop_front());
            end
        end
    endtask

    function automatic logic [31:0] draw_value();
        int          pick;
        logic [31:0] v;
        pick = $urandom_range(0, 15);
        if (pick < 4 && value_pool.size() > 0) begin
            v = value_pool[$urandom_range(0, value_pool.size() - 1)];
        end else if (pick < 6) begin
            case ($urandom_range(0, 3))
                0: v = VALUE_MIN;
                1: v = VALUE_MAX;
                2: v = '0;
                default: v = VALUE_ALL_ONES;
            endcase
        end else if (pick < 8) begin
            v = $urandom_range(0, 3);
        end else begin
            v = $urandom();
        end
        return v;
    endfunction

    function automatic logic [5:0] draw_position();
        if (list_len_guess > 0 && $urandom_range(0, 99) < 85) begin
            return 6'($urandom_range(0, list_len_guess - 1));
        end
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [2:0] draw_kind(input t_mode mode);
        int r;
        int push_w;
        int read_w;
        int write_w;
        int remove_w;
        int find_w;
        case (mode)
            MODE_GROW: begin
                push_w = 75; read_w = 6; write_w = 6; remove_w = 4; find_w = 7;
            end
            MODE_SHRINK: begin
                push_w = 10; read_w = 10; write_w = 10; remove_w = 55; find_w = 12;
            end
            default: begin
                push_w = 30; read_w = 20; write_w = 15; remove_w = 15; find_w = 17;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < push_w) return KIND_PUSH;
        r -= push_w;
        if (r < read_w) return KIND_READ;
        r -= read_w;
        if (r < write_w) return KIND_WRITE;
        r -= write_w;
        if (r < remove_w) return KIND_REMOVE;
        r -= remove_w;
        if (r < find_w) return KIND_FIND;
        return 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every access on the empty list, then a small list with duplicates.
        send_item(KIND_READ, 6'd0, '0);
        send_item(KIND_REMOVE, 6'd0, '0);
        send_item(KIND_WRITE, 6'd0, VALUE_MAX);
        send_item(KIND_FIND, 6'd0, '0);
        send_item(KIND_PUSH, 6'd0, VALUE_MIN);
        send_item(KIND_PUSH, 6'd0, VALUE_MAX);
        send_item(KIND_PUSH, 6'd0, '0);
        send_item(KIND_PUSH, 6'd0, VALUE_ALL_ONES);
        send_item(KIND_PUSH, 6'd0, VALUE_MIN);
        send_item(KIND_FIND, 6'd0, VALUE_MIN);
        send_item(KIND_READ, 6'd0, '0);
        send_item(KIND_READ, 6'd4, '0);
        send_item(KIND_READ, 6'd5, '0);
        send_item(KIND_WRITE, POS_LAST, VALUE_ALL_ONES);
        send_item(KIND_WRITE, 6'd2, 32'd5);
        send_item(KIND_FIND, POS_LAST, 32'd5);
        send_item(KIND_FIND, POS_LAST, 32'd12345);
        send_item(KIND_REMOVE, 6'd1, '0);
        send_item(KIND_REMOVE, 6'd3, '0);
        send_item(KIND_READ, 6'd3, '0);
        send_item(KIND_READ, POS_LAST, '0);
        send_item(KIND_UNUSED_FIRST, POS_LAST, VALUE_MAX);
        send_item(KIND_UNUSED_FIRST + 3'd1, 6'd0, VALUE_MIN);
        send_item(KIND_UNUSED_LAST, POS_LAST, VALUE_ALL_ONES);

        // Bursts alternate between filling the list, emptying it and a mix.
        for (int b = 0; b < RANDOM_ITEMS / BURST_ITEMS; b++) begin
            t_mode       mode;
            logic [2:0]  kind;
            logic [31:0] value;
            mode = (b % 2 == 1) ? MODE_MIXED : ((b % 4 == 0) ? MODE_GROW : MODE_SHRINK);
            no_idle <= (b % 3 == 2);
            for (int i = 0; i < BURST_ITEMS; i++) begin
                kind = draw_kind(mode);
                if (kind == KIND_FIND && value_pool.size() > 0 &&
                    $urandom_range(0, 9) < 6) begin
                    value = value_pool[$urandom_range(0, value_pool.size() - 1)];
                end else begin
                    value = draw_value();
                end
                send_item(kind, draw_position(), value);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d push, %0d read, %0d write, %0d remove, %0d find, %0d unused-kind.",
                 kind_count[KIND_PUSH], kind_count[KIND_READ], kind_count[KIND_WRITE],
                 kind_count[KIND_REMOVE], kind_count[KIND_FIND],
                 kind_count[KIND_UNUSED_FIRST] + kind_count[KIND_UNUSED_FIRST + 3'd1] +
                 kind_count[KIND_UNUSED_LAST]);
        $display("Checked %0d results: %0d pushes dropped when full, %0d out-of-range accesses.",
                 checked, full_drops, range_hits);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
